// ===== hdl/spie_pkg.sv =====
`default_nettype none

package spie_pkg;

    localparam int CORDIC_STAGES = 32;

    // pipeline stage indices; the CORDIC occupies stages 8 .. CORDIC_STAGES+7
    localparam int ST_QUAD = 3;
    localparam int ST_R2   = CORDIC_STAGES + 9;
    localparam int ST_P9   = CORDIC_STAGES + 18;
    localparam int NUM_ST  = CORDIC_STAGES + 25;

    // register indices (byte address 8*index)
    localparam logic [2:0] REG_SIN_LON = 3'd0;
    localparam logic [2:0] REG_COS_LON = 3'd1;
    localparam logic [2:0] REG_SIN_LAT = 3'd2;
    localparam logic [2:0] REG_COS_LAT = 3'd3;
    localparam logic [2:0] REG_SIN_PA  = 3'd4;
    localparam logic [2:0] REG_COS_PA  = 3'd5;
    localparam logic [2:0] REG_MAJOR   = 3'd6;
    localparam logic [2:0] REG_MINOR   = 3'd7;

    localparam logic signed [31:0] Q30_ONE32 = 32'sd1073741824;
    localparam logic signed [63:0] Q30_ONE   = 64'sd1073741824;
    localparam logic signed [63:0] Q30_HALF  = 64'sd536870912;
    localparam logic signed [35:0] SUM_LIM   = 36'sd2147483648;

    // angles in 2^-24 degree
    localparam logic signed [35:0] DEG_90  = 36'sd1509949440;
    localparam logic signed [35:0] DEG_180 = 36'sd3019898880;
    localparam logic signed [35:0] DEG_360 = 36'sd6039797760;
    localparam logic signed [35:0] DEG_720 = 36'sd12079595520;

    localparam logic [63:0] PI61    = 64'h6487ED5110B4611A;
    localparam logic [63:0] DEG_RAD = PI61 / 180;
    localparam logic [31:0] D_HI    = 32'(DEG_RAD >> 24);
    localparam logic [23:0] D_LO    = DEG_RAD[23:0];

    localparam logic signed [63:0] CORDIC_X0 = 64'sh26DD3B6A << 30;

    typedef struct packed {
        logic [37:0] ll;
        logic [37:0] lh;
        logic [37:0] hl;
        logic [37:0] hh;
    } t_pp4;

    typedef struct packed {
        logic [51:0] p00;
        logic [51:0] p01;
        logic [51:0] p11;
        logic [51:0] p02;
        logic [51:0] p12;
        logic [51:0] p22;
    } t_sq6;

    typedef struct packed {
        logic [79:0] lo;
        logic [53:0] mid;
        logic [78:0] hi;
    } t_sq3;

    // atan(2^-i) in 2^-61 rad, series terms by shift-subtract division
    function automatic logic signed [63:0] atan_unit(input int i);
        logic signed [63:0] sum;
        logic [63:0] num;
        logic [63:0] q;
        logic [64:0] rem;
        int k;
        int b;
        int e;
        int d;
        sum = '0;
        if (i == 0) begin
            sum = $signed(PI61 >> 2);
        end else begin
            for (k = 0; k < 32; k++) begin
                e = 61 - (2 * k + 1) * i;
                if (e >= 0) begin
                    d   = 2 * k + 1;
                    num = 64'd1 << e;
                    q   = '0;
                    rem = '0;
                    for (b = 63; b >= 0; b--) begin
                        rem = {rem[63:0], num[b]};
                        if (rem >= 65'(d)) begin
                            rem  = rem - 65'(d);
                            q[b] = 1'b1;
                        end
                    end
                    if (k % 2 == 1) sum = sum - $signed(q);
                    else            sum = sum + $signed(q);
                end
            end
        end
        return sum;
    endfunction

    function automatic logic signed [31:0] q30_round(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + Q30_HALF) >>> 30;
        if (t > Q30_ONE)       t = Q30_ONE;
        else if (t < -Q30_ONE) t = -Q30_ONE;
        return 32'(t);
    endfunction

    function automatic logic signed [32:0] clamp_sum(input logic signed [35:0] v);
        logic signed [35:0] t;
        t = v;
        if (v > SUM_LIM)       t = SUM_LIM;
        else if (v < -SUM_LIM) t = -SUM_LIM;
        return 33'(t);
    endfunction

    function automatic t_pp4 pp4(input logic [37:0] a, input logic [37:0] b);
        t_pp4 r;
        r.ll = 38'(a[18:0]) * 38'(b[18:0]);
        r.lh = 38'(a[18:0]) * 38'(b[37:19]);
        r.hl = 38'(a[37:19]) * 38'(b[18:0]);
        r.hh = 38'(a[37:19]) * 38'(b[37:19]);
        return r;
    endfunction

    function automatic logic [75:0] sum_pp4(input t_pp4 p);
        return 76'(p.ll) + (76'(p.lh) << 19) + (76'(p.hl) << 19) + (76'(p.hh) << 38);
    endfunction

    function automatic t_sq6 sq_pp(input logic [75:0] a);
        logic [77:0] w;
        t_sq6 r;
        w     = 78'(a);
        r.p00 = 52'(w[25:0])  * 52'(w[25:0]);
        r.p01 = 52'(w[25:0])  * 52'(w[51:26]);
        r.p11 = 52'(w[51:26]) * 52'(w[51:26]);
        r.p02 = 52'(w[25:0])  * 52'(w[77:52]);
        r.p12 = 52'(w[51:26]) * 52'(w[77:52]);
        r.p22 = 52'(w[77:52]) * 52'(w[77:52]);
        return r;
    endfunction

    function automatic t_sq3 sq_grp(input t_sq6 p);
        t_sq3 r;
        r.lo  = 80'(p.p00) + (80'(p.p01) << 27);
        r.mid = 54'(p.p11) + (54'(p.p02) << 1);
        r.hi  = (79'(p.p12) << 1) + (79'(p.p22) << 26);
        return r;
    endfunction

    function automatic logic [151:0] sq_sum(input t_sq3 g);
        logic [159:0] t;
        t = 160'(g.lo) + (160'(g.mid) << 52) + (160'(g.hi) << 78);
        return t[151:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sky_point_in_ellipse_test.sv =====
// Throughput: one item per cycle unless the output stalls; every stage is a register, the
// CORDIC takes one stage per iteration and the wide ellipse products are split into 19- and
// 26-bit partial products.
// A result held at the output with tready low stalls the whole pipeline.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults:
// trig cosines 1.0, sines 0, both axes 0.
`default_nettype none

module sky_point_in_ellipse_test
    import spie_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // [33:0] point_lon, [66:34] point_lat
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [0] inside_res, [1] fault
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    // configuration
    logic signed [31:0] r_s_lon, r_c_lon, r_s_lat, r_c_lat, r_s_pa, r_c_pa;
    logic [37:0]        r_major, r_minor;

    logic pipe_en;
    logic r_vld [NUM_ST];
    logic r_flt [NUM_ST-1];
    logic r_flip [ST_QUAD:ST_R2-1];
    logic r_ok [ST_P9:NUM_ST-2];

    // front end
    logic signed [33:0] r_lon0;
    logic signed [32:0] r_lat0, r_lat1, r_lat2, r_lat3;
    logic signed [35:0] r_lon1, r_lon2, r_lon3;
    logic signed [35:0] n_lon1, n_lon3, c_abs_lon;
    logic signed [33:0] c_abs_lat;
    logic               n_flip;
    logic [30:0]        r_mag_lon, r_mag_lat;
    logic               r_neg_lon4, r_neg_lat4, r_neg_lon5, r_neg_lat5, r_neg_lon6, r_neg_lat6;
    logic [62:0]        r_ph_lon, r_ph_lat, r_r_lon, r_r_lat;
    logic [54:0]        r_pl_lon, r_pl_lat;
    logic signed [63:0] r_z_lon, r_z_lat;

    // CORDIC
    logic signed [63:0] r_xl [CORDIC_STAGES];
    logic signed [63:0] r_yl [CORDIC_STAGES];
    logic signed [63:0] r_zl [CORDIC_STAGES];
    logic signed [63:0] r_xb [CORDIC_STAGES];
    logic signed [63:0] r_yb [CORDIC_STAGES];
    logic signed [63:0] r_zb [CORDIC_STAGES];

    // projection
    logic signed [31:0] r_cl, r_sl, r_cb, r_sb, r_cl2, r_sl2, r_cb2, r_sb2, r_vz;
    logic signed [63:0] r_vxp, r_vyp;
    logic signed [31:0] c_vx, c_vy;
    logic signed [63:0] r_p_slvy, r_p_clvx, r_p_clvy, r_p_slvx, r_p_ctvz;
    logic signed [32:0] r_t1, r_yne, r_yne4, r_yne5, r_xne, r_x, r_y;
    logic signed [35:0] r_ctvz3, r_ctvz4;
    logic signed [64:0] r_p_stt1;
    logic signed [64:0] r_p_spy, r_p_cpx, r_p_cpy, r_p_spx;
    logic signed [32:0] c_ax, c_ay;
    logic [41:0]        r_bx, r_by;

    // ellipse test
    t_pp4         r_pa, r_pb, r_pc;
    logic [75:0]  r_a, r_b, r_c;
    t_sq6         r_sa, r_sb6, r_sc;
    t_sq3         r_ga, r_gb, r_gc;
    logic [151:0] r_a2, r_b2, r_c2, r_c2b;
    logic [152:0] r_sab;
    logic         r_inside, r_fault;

    // ---------------------------------------------------------------- config port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_lon <= '0;
            r_c_lon <= Q30_ONE32;
            r_s_lat <= '0;
            r_c_lat <= Q30_ONE32;
            r_s_pa  <= '0;
            r_c_pa  <= Q30_ONE32;
            r_major <= '0;
            r_minor <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[5:3])
                REG_SIN_LON: r_s_lon <= pwdata[31:0];
                REG_COS_LON: r_c_lon <= pwdata[31:0];
                REG_SIN_LAT: r_s_lat <= pwdata[31:0];
                REG_COS_LAT: r_c_lat <= pwdata[31:0];
                REG_SIN_PA:  r_s_pa  <= pwdata[31:0];
                REG_COS_PA:  r_c_pa  <= pwdata[31:0];
                REG_MAJOR:   r_major <= pwdata[37:0];
                REG_MINOR:   r_minor <= pwdata[37:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_SIN_LON: prdata = {32'd0, r_s_lon};
            REG_COS_LON: prdata = {32'd0, r_c_lon};
            REG_SIN_LAT: prdata = {32'd0, r_s_lat};
            REG_COS_LAT: prdata = {32'd0, r_c_lat};
            REG_SIN_PA:  prdata = {32'd0, r_s_pa};
            REG_COS_PA:  prdata = {32'd0, r_c_pa};
            REG_MAJOR:   prdata = {26'd0, r_major};
            REG_MINOR:   prdata = {26'd0, r_minor};
        endcase
    end

    // ---------------------------------------------------------------- pipeline control
    assign pipe_en       = m_axis_tready || !r_vld[NUM_ST-1];
    assign s_axis_tready = pipe_en;
    assign m_axis_tvalid = r_vld[NUM_ST-1];
    assign m_axis_tdata  = {6'd0, r_fault, r_inside};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_ST; k++) r_vld[k] <= 1'b0;
        end else if (pipe_en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < NUM_ST; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // per-item flags riding alongside the data
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_flt[0] <= ($signed(s_axis_tdata[66:34]) < -DEG_90)
                     || ($signed(s_axis_tdata[66:34]) > DEG_90)
                     || (r_minor > r_major);
            for (int k = 1; k < NUM_ST-1; k++) r_flt[k] <= r_flt[k-1];
            r_flip[ST_QUAD] <= n_flip;
            for (int k = ST_QUAD+1; k < ST_R2; k++) r_flip[k] <= r_flip[k-1];
            r_ok[ST_P9] <= (r_minor != '0) && (r_bx <= 42'(r_major))
                        && (r_by <= 42'(r_minor));
            for (int k = ST_P9+1; k < NUM_ST-1; k++) r_ok[k] <= r_ok[k-1];
        end
    end

    // ---------------------------------------------------------------- angle reduction
    always_comb begin
        if (36'(r_lon0) < -DEG_360)  n_lon1 = 36'(r_lon0) + DEG_720;
        else if (r_lon0 < 0)         n_lon1 = 36'(r_lon0) + DEG_360;
        else if (36'(r_lon0) >= DEG_360) n_lon1 = 36'(r_lon0) - DEG_360;
        else                         n_lon1 = 36'(r_lon0);
    end

    // fold into +/-90 degrees, the sine and cosine then change sign
    always_comb begin
        n_flip = 1'b1;
        if (r_lon2 > DEG_90)       n_lon3 = r_lon2 - DEG_180;
        else if (r_lon2 < -DEG_90) n_lon3 = r_lon2 + DEG_180;
        else begin
            n_lon3 = r_lon2;
            n_flip = 1'b0;
        end
    end

    assign c_abs_lon = (r_lon3 < 0) ? -r_lon3 : r_lon3;
    assign c_abs_lat = (r_lat3 < 0) ? -34'(r_lat3) : 34'(r_lat3);

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_lon0 <= $signed(s_axis_tdata[33:0]);
            r_lat0 <= $signed(s_axis_tdata[66:34]);
            r_lon1 <= n_lon1;
            r_lat1 <= r_lat0;
            r_lon2 <= (r_lon1 >= DEG_180) ? r_lon1 - DEG_360 : r_lon1;
            r_lat2 <= r_lat1;
            r_lon3 <= n_lon3;
            r_lat3 <= r_lat2;
            r_mag_lon  <= c_abs_lon[30:0];
            r_mag_lat  <= c_abs_lat[30:0];
            r_neg_lon4 <= r_lon3 < 0;
            r_neg_lat4 <= r_lat3 < 0;
            // degrees to 2^-61 rad in two partial products
            r_ph_lon   <= 63'(r_mag_lon) * 63'(D_HI);
            r_pl_lon   <= 55'(r_mag_lon) * 55'(D_LO);
            r_ph_lat   <= 63'(r_mag_lat) * 63'(D_HI);
            r_pl_lat   <= 55'(r_mag_lat) * 55'(D_LO);
            r_neg_lon5 <= r_neg_lon4;
            r_neg_lat5 <= r_neg_lat4;
            r_r_lon    <= r_ph_lon + 63'(r_pl_lon >> 24);
            r_r_lat    <= r_ph_lat + 63'(r_pl_lat >> 24);
            r_neg_lon6 <= r_neg_lon5;
            r_neg_lat6 <= r_neg_lat5;
            r_z_lon    <= r_neg_lon6 ? -$signed({1'b0, r_r_lon}) : $signed({1'b0, r_r_lon});
            r_z_lat    <= r_neg_lat6 ? -$signed({1'b0, r_r_lat}) : $signed({1'b0, r_r_lat});
        end
    end

    // ---------------------------------------------------------------- CORDIC, one stage each
    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
        localparam logic signed [63:0] ANG = atan_unit(gi);
        logic signed [63:0] xl, yl, zl, xb, yb, zb;

        if (gi == 0) begin : g_first
            assign xl = CORDIC_X0;
            assign yl = '0;
            assign zl = r_z_lon;
            assign xb = CORDIC_X0;
            assign yb = '0;
            assign zb = r_z_lat;
        end else begin : g_next
            assign xl = r_xl[gi-1];
            assign yl = r_yl[gi-1];
            assign zl = r_zl[gi-1];
            assign xb = r_xb[gi-1];
            assign yb = r_yb[gi-1];
            assign zb = r_zb[gi-1];
        end

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                if (zl >= 0) begin
                    r_xl[gi] <= xl - (yl >>> gi);
                    r_yl[gi] <= yl + (xl >>> gi);
                    r_zl[gi] <= zl - ANG;
                end else begin
                    r_xl[gi] <= xl + (yl >>> gi);
                    r_yl[gi] <= yl - (xl >>> gi);
                    r_zl[gi] <= zl + ANG;
                end
                if (zb >= 0) begin
                    r_xb[gi] <= xb - (yb >>> gi);
                    r_yb[gi] <= yb + (xb >>> gi);
                    r_zb[gi] <= zb - ANG;
                end else begin
                    r_xb[gi] <= xb + (yb >>> gi);
                    r_yb[gi] <= yb - (xb >>> gi);
                    r_zb[gi] <= zb + ANG;
                end
            end
        end
    end

    // ---------------------------------------------------------------- unit vector and projection
    assign c_vx = 32'(r_vxp >>> 30);
    assign c_vy = 32'(r_vyp >>> 30);
    assign c_ax = (r_x < 0) ? -r_x : r_x;
    assign c_ay = (r_y < 0) ? -r_y : r_y;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_cl  <= q30_round(r_xl[CORDIC_STAGES-1]);
            r_sl  <= q30_round(r_yl[CORDIC_STAGES-1]);
            r_cb  <= q30_round(r_xb[CORDIC_STAGES-1]);
            r_sb  <= q30_round(r_yb[CORDIC_STAGES-1]);
            r_cl2 <= r_flip[ST_R2-1] ? -r_cl : r_cl;
            r_sl2 <= r_flip[ST_R2-1] ? -r_sl : r_sl;
            r_cb2 <= r_cb;
            r_sb2 <= r_sb;
            r_vxp <= 64'(r_cb2) * 64'(r_cl2);
            r_vyp <= 64'(r_cb2) * 64'(r_sl2);
            r_vz  <= r_sb2;
            r_p_slvy <= 64'(r_s_lon) * 64'(c_vy);
            r_p_clvx <= 64'(r_c_lon) * 64'(c_vx);
            r_p_clvy <= 64'(r_c_lon) * 64'(c_vy);
            r_p_slvx <= 64'(r_s_lon) * 64'(c_vx);
            r_p_ctvz <= 64'(r_c_lat) * 64'(r_vz);
            r_t1    <= clamp_sum(36'(r_p_slvy >>> 30) + 36'(r_p_clvx >>> 30));
            r_yne   <= clamp_sum(36'(r_p_clvy >>> 30) - 36'(r_p_slvx >>> 30));
            r_ctvz3 <= 36'(r_p_ctvz >>> 30);
            r_p_stt1 <= 65'(r_s_lat) * 65'(r_t1);
            r_yne4   <= r_yne;
            r_ctvz4  <= r_ctvz3;
            r_xne  <= clamp_sum(r_ctvz4 - 36'(r_p_stt1 >>> 30));
            r_yne5 <= r_yne4;
            // rotate by position angle
            r_p_spy <= 65'(r_s_pa) * 65'(r_yne5);
            r_p_cpx <= 65'(r_c_pa) * 65'(r_xne);
            r_p_cpy <= 65'(r_c_pa) * 65'(r_yne5);
            r_p_spx <= 65'(r_s_pa) * 65'(r_xne);
            r_x <= clamp_sum(36'(r_p_spy >>> 30) + 36'(r_p_cpx >>> 30));
            r_y <= clamp_sum(36'(r_p_cpy >>> 30) - 36'(r_p_spx >>> 30));
            r_bx <= {c_ax[31:0], 10'd0};
            r_by <= {c_ay[31:0], 10'd0};
        end
    end

    // ---------------------------------------------------------------- exact ellipse compare
    // X, Y only matter when they lie within the axes, so 38 bits suffice
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_pa  <= pp4(r_bx[37:0], r_minor);
            r_pb  <= pp4(r_by[37:0], r_major);
            r_pc  <= pp4(r_major, r_minor);
            r_a   <= sum_pp4(r_pa);
            r_b   <= sum_pp4(r_pb);
            r_c   <= sum_pp4(r_pc);
            r_sa  <= sq_pp(r_a);
            r_sb6 <= sq_pp(r_b);
            r_sc  <= sq_pp(r_c);
            r_ga  <= sq_grp(r_sa);
            r_gb  <= sq_grp(r_sb6);
            r_gc  <= sq_grp(r_sc);
            r_a2  <= sq_sum(r_ga);
            r_b2  <= sq_sum(r_gb);
            r_c2  <= sq_sum(r_gc);
            r_sab <= 153'(r_a2) + 153'(r_b2);
            r_c2b <= r_c2;
            r_inside <= !r_flt[NUM_ST-2] && r_ok[NUM_ST-2] && (r_sab <= 153'(r_c2b));
            r_fault  <= r_flt[NUM_ST-2];
        end
    end

    // ---------------------------------------------------------------- checks
    a_fault_not_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("inside flag raised together with fault");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NUM_ST-1] && !m_axis_tready) |=> $stable(r_vld[0]) && $stable(r_vld[ST_R2]))
        else $error("pipeline moved during output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_R2-1] |-> (r_cl <= Q30_ONE32) && (r_cl >= -Q30_ONE32))
        else $error("CORDIC cosine outside unit range");

endmodule

`default_nettype wire
